>>> design/lmps_pkg.sv
package lmps_pkg;

    // Width of the saturating second counters
    localparam int COUNTER_WIDTH = 16;
    // Width at which counters and 16-bit timeout registers are compared
    localparam int CMP_W = (COUNTER_WIDTH > 16) ? COUNTER_WIDTH : 16;

    localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = {COUNTER_WIDTH{1'b1}};

    // Input commands
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_POLL  = 2'd1,
        CMD_FRAME = 2'd2
    } cmd_t;

    // Register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_STATION_ADDR = 2'd0,
        REG_LINK_TIMEOUT = 2'd1,
        REG_GI_PERIOD    = 2'd2,
        REG_IDLE_TIMEOUT = 2'd3
    } reg_idx_t;

    // Link states, one-hot
    typedef enum logic [4:0] {
        LS_RESET   = 5'b00001,
        LS_REQ_STS = 5'b00010,
        LS_CLASS1  = 5'b00100,
        LS_CLASS2  = 5'b01000,
        LS_GI      = 5'b10000
    } link_state_t;

    // Output frame kinds
    localparam logic FRAME_FIXED = 1'b0;
    localparam logic FRAME_GI    = 1'b1;

    // Control field pieces
    localparam logic [7:0] CTRL_PRM  = 8'h40;
    localparam logic [7:0] CTRL_FCB  = 8'h20;
    localparam logic [7:0] CTRL_FCV  = 8'h10;
    localparam logic [7:0] CTRL_ACD  = 8'h20;

    // Function codes
    localparam logic [3:0] FC_RESET_LINK = 4'd0;
    localparam logic [3:0] FC_GI         = 4'd3;
    localparam logic [3:0] FC_CLASS1     = 4'd10;
    localparam logic [3:0] FC_CLASS2     = 4'd11;

    // Fixed bytes of the general interrogation data unit
    localparam logic [7:0] ASDU_TYPE_GI = 8'h07;
    localparam logic [7:0] ASDU_VSQ     = 8'h81;
    localparam logic [7:0] ASDU_COT_GI  = 8'h09;
    localparam logic [7:0] ASDU_FUN     = 8'hff;
    localparam logic [7:0] GI_CONST_SUM = ASDU_TYPE_GI + ASDU_VSQ + ASDU_COT_GI + ASDU_FUN;

    // Reset values of the configuration registers
    localparam logic [7:0]  RST_STATION_ADDR = 8'd1;
    localparam logic [15:0] RST_LINK_TIMEOUT = 16'd10;
    localparam logic [15:0] RST_GI_PERIOD    = 16'd900;
    localparam logic [15:0] RST_IDLE_TIMEOUT = 16'd50;

    function automatic logic [7:0] make_control(logic fcb, logic fcv, logic [3:0] code);
        logic [7:0] c;
        c = CTRL_PRM | {4'h0, code};
        if (fcb) c = c | CTRL_FCB;
        if (fcv) c = c | CTRL_FCV;
        return c;
    endfunction

endpackage

>>> design/link_master_poll_sequencer.sv
// Master-side link layer sequencer for a serial telecontrol link.
//
// Input channel (s_*): one beat per event. s_command selects a one-second
// tick, a send opportunity (poll) or a received frame; s_frame_variable and
// s_control_field describe the received frame. Result channel (m_*): one
// beat per poll that yields a frame, carrying the frame kind, its control
// byte and its checksum. Ticks, received frames, unknown commands and polls
// in an unused link state produce no beat.
// An accepted beat is captured in the input register, processed once the
// result register can take a beat, and its result is presented from the
// result register. Throughput is one beat per cycle while the result
// register drains (m_ready high), limited only by the single input and
// result registers.
// Stall: while m_ready is low and a result waits, the input register holds
// its beat and s_ready drops once it is full; nothing is lost or repeated.
// Reset (aresetn low, synchronous): both registers empty, link state back to
// request link status, count bit, pending flag and counters cleared, and
// the APB registers back to their defaults. The APB port (pready always
// high) must be written by the user only while the block is idle; the block does not enforce it.
module link_master_poll_sequencer
    import lmps_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic        s_frame_variable,
    input  logic [7:0]  s_control_field,
    // Result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_frame_kind,
    output logic [7:0]  m_control_byte,
    output logic [7:0]  m_checksum
);

    // Configuration registers
    logic [7:0]  station_addr_reg;
    logic [15:0] link_timeout_reg;
    logic [15:0] gi_period_reg;
    logic [15:0] idle_timeout_reg;

    // Input register
    logic        in_valid_reg;
    logic [1:0]  in_command_reg;
    logic        in_variable_reg;
    logic [7:0]  in_control_reg;

    // Link state
    link_state_t              link_state_reg, link_state_next;
    logic                     count_bit_reg, count_bit_next;
    logic                     pending_reg, pending_next;
    logic [COUNTER_WIDTH-1:0] secs_reply_reg, secs_reply_next;
    logic [COUNTER_WIDTH-1:0] secs_gi_reg, secs_gi_next;

    // Result register
    logic        out_valid_reg, out_valid_next;
    logic        out_kind_reg, out_kind_next;
    logic [7:0]  out_ctrl_reg, out_ctrl_next;
    logic [7:0]  out_sum_reg, out_sum_next;

    logic        advance;
    logic        cfg_write;
    logic        link_expired, gi_due, idle_expired;
    logic [7:0]  ctrl_byte;
    logic        emit, emit_gi;
    logic [7:0]  sum_fixed, sum_gi;
    link_state_t eff_state;

    // The input register moves on whenever the result register can take a beat
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;

    assign m_valid        = out_valid_reg;
    assign m_frame_kind   = out_kind_reg;
    assign m_control_byte = out_ctrl_reg;
    assign m_checksum     = out_sum_reg;

    // APB: zero wait states, word index in paddr[3:2]
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        prdata = 32'h0;
        case (reg_idx_t'(paddr[3:2]))
            REG_STATION_ADDR: prdata = {24'h0, station_addr_reg};
            REG_LINK_TIMEOUT: prdata = {16'h0, link_timeout_reg};
            REG_GI_PERIOD:    prdata = {16'h0, gi_period_reg};
            REG_IDLE_TIMEOUT: prdata = {16'h0, idle_timeout_reg};
            default:          prdata = 32'h0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            station_addr_reg <= RST_STATION_ADDR;
            link_timeout_reg <= RST_LINK_TIMEOUT;
            gi_period_reg    <= RST_GI_PERIOD;
            idle_timeout_reg <= RST_IDLE_TIMEOUT;
        end else if (cfg_write) begin
            case (reg_idx_t'(paddr[3:2]))
                REG_STATION_ADDR: station_addr_reg <= pwdata[7:0];
                REG_LINK_TIMEOUT: link_timeout_reg <= pwdata[15:0];
                REG_GI_PERIOD:    gi_period_reg    <= pwdata[15:0];
                REG_IDLE_TIMEOUT: idle_timeout_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Timer comparisons at a common width
    assign link_expired = CMP_W'(secs_reply_reg) > CMP_W'(link_timeout_reg);
    assign gi_due       = CMP_W'(secs_gi_reg)    > CMP_W'(gi_period_reg);
    assign idle_expired = CMP_W'(secs_reply_reg) > CMP_W'(idle_timeout_reg);

    // A stale link forces a restart before the poll is served
    assign eff_state = link_expired ? LS_REQ_STS : link_state_reg;

    // Checksums: control + address, or the whole interrogation data unit
    assign sum_fixed = ctrl_byte + station_addr_reg;
    assign sum_gi    = ctrl_byte + station_addr_reg + station_addr_reg + GI_CONST_SUM;

    always_comb begin
        link_state_next = link_state_reg;
        count_bit_next  = count_bit_reg;
        pending_next    = pending_reg;
        secs_reply_next = secs_reply_reg;
        secs_gi_next    = secs_gi_reg;
        emit            = 1'b0;
        emit_gi         = 1'b0;
        ctrl_byte       = make_control(count_bit_reg, 1'b0, FC_RESET_LINK);

        if (in_valid_reg && advance) begin
            case (cmd_t'(in_command_reg))
                CMD_TICK: begin
                    if (secs_reply_reg != CNT_MAX) secs_reply_next = secs_reply_reg + 1'b1;
                    if (secs_gi_reg != CNT_MAX)    secs_gi_next    = secs_gi_reg + 1'b1;
                end
                CMD_FRAME: begin
                    secs_reply_next = '0;
                    count_bit_next  = !count_bit_reg;
                    if ((in_control_reg & CTRL_ACD) != 8'h0) begin
                        link_state_next = LS_CLASS1;
                    end else if (!in_variable_reg && pending_reg) begin
                        pending_next    = 1'b0;
                        link_state_next = LS_GI;
                    end else begin
                        link_state_next = LS_CLASS2;
                    end
                end
                CMD_POLL: begin
                    link_state_next = eff_state;
                    case (eff_state)
                        LS_RESET: begin
                            emit = 1'b1;
                        end
                        LS_REQ_STS: begin
                            emit            = 1'b1;
                            link_state_next = LS_GI;
                            pending_next    = 1'b1;
                        end
                        LS_CLASS1: begin
                            emit      = 1'b1;
                            ctrl_byte = make_control(count_bit_reg, 1'b1, FC_CLASS1);
                        end
                        LS_CLASS2: begin
                            emit = 1'b1;
                            if (gi_due) begin
                                secs_gi_next = '0;
                                emit_gi      = 1'b1;
                            end else if (pending_reg) begin
                                pending_next = 1'b0;
                                emit_gi      = 1'b1;
                            end else if (idle_expired) begin
                                link_state_next = LS_GI;
                                pending_next    = 1'b1;
                            end else begin
                                ctrl_byte = make_control(count_bit_reg, 1'b1, FC_CLASS2);
                            end
                        end
                        LS_GI: begin
                            emit    = 1'b1;
                            emit_gi = 1'b1;
                        end
                        default: ;
                    endcase
                    if (emit_gi) ctrl_byte = make_control(count_bit_reg, 1'b1, FC_GI);
                end
                default: ;
            endcase
        end
    end

    // Result register: load on advance, drop once taken
    always_comb begin
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_ctrl_next  = out_ctrl_reg;
        out_sum_next   = out_sum_reg;
        if (advance) begin
            out_valid_next = in_valid_reg && emit;
            out_kind_next  = emit_gi ? FRAME_GI : FRAME_FIXED;
            out_ctrl_next  = ctrl_byte;
            out_sum_next   = emit_gi ? sum_gi : sum_fixed;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            link_state_reg <= LS_REQ_STS;
            count_bit_reg  <= 1'b0;
            pending_reg    <= 1'b0;
            secs_reply_reg <= '0;
            secs_gi_reg    <= '0;
        end else begin
            if (s_ready) in_valid_reg <= s_valid;
            out_valid_reg  <= out_valid_next;
            link_state_reg <= link_state_next;
            count_bit_reg  <= count_bit_next;
            pending_reg    <= pending_next;
            secs_reply_reg <= secs_reply_next;
            secs_gi_reg    <= secs_gi_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_command_reg  <= s_command;
            in_variable_reg <= s_frame_variable;
            in_control_reg  <= s_control_field;
        end
        out_kind_reg <= out_kind_next;
        out_ctrl_reg <= out_ctrl_next;
        out_sum_reg  <= out_sum_next;
    end

endmodule

>>> dv/link_master_poll_sequencer_test.sv
`timescale 1ns / 1ps

module link_master_poll_sequencer_test;
    import lmps_pkg::*;

    // The block ignores command code 3; it has no member in cmd_t
    localparam logic [1:0] CMD_RESERVED = 2'd3;
    // Cycles of silence on every port before the run is declared hung
    localparam int HANG_LIMIT = 5000;
    // Cycles to let the input and result registers drain before a register write
    localparam int DRAIN_CYCLES = 8;
    localparam int TAIL_CYCLES = 20;
    localparam int ITEMS_PER_PHASE = 300;
    localparam int PHASES = 6;
    // Timeout used to probe the strict compare at its boundary
    localparam logic [15:0] EDGE_SECS = 16'd20;

    typedef struct packed {
        logic       kind;
        logic [7:0] ctrl;
        logic [7:0] sum;
    } link_frame_t;

    // One row of the directed script: an event, how many times to send it, and,
    // where the answer is obvious, the frame it must produce
    typedef struct packed {
        logic [1:0]  cmd;
        logic        is_variable;
        logic [7:0]  ctrl;
        logic [7:0]  repeats;
        logic        typed;
        link_frame_t want;
    } script_row_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_COMB
    } rx_mode_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_command = CMD_TICK;
    logic        s_frame_variable = 1'b0;
    logic [7:0]  s_control_field = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_frame_kind;
    logic [7:0]  m_control_byte;
    logic [7:0]  m_checksum;

    link_master_poll_sequencer dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_frame_variable (s_frame_variable),
        .s_control_field  (s_control_field),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_frame_kind     (m_frame_kind),
        .m_control_byte   (m_control_byte),
        .m_checksum       (m_checksum)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Shadow of the block: register copies and link state
    logic [7:0]               cfg_station;
    logic [15:0]              cfg_link_to;
    logic [15:0]              cfg_gi_period;
    logic [15:0]              cfg_idle_to;
    link_state_t              link_st;
    logic                     fcb;
    logic                     gi_pending;
    logic [COUNTER_WIDTH-1:0] reply_secs;
    logic [COUNTER_WIDTH-1:0] gi_secs;

    link_frame_t frames_due[$];
    link_frame_t head;
    int          mismatches = 0;
    int          quiet_cycles = 0;
    int          burst_left = 0;
    rx_mode_t    rx_mode = RX_OPEN;
    int          rx_left = 0;
    int          rx_count = 0;

    // Directed script, walked once straight after reset with the default registers
    script_row_t script [0:20] = '{
        // after reset the first poll asks for link status: 0x40, sum 0x40 + 1
        '{CMD_POLL,     1'b0, 8'h00, 8'd1,  1'b1, '{FRAME_FIXED, 8'h40, 8'h41}},
        // then the interrogation request, count bit still clear
        '{CMD_POLL,     1'b0, 8'h00, 8'd1,  1'b1, '{FRAME_GI, 8'h53, 8'hE5}},
        '{CMD_RESERVED, 1'b1, 8'hFF, 8'd1,  1'b0, '0},
        // fixed reply while interrogation is pending keeps the GI state
        '{CMD_FRAME,    1'b0, 8'h00, 8'd1,  1'b0, '0},
        '{CMD_POLL,     1'b0, 8'h00, 8'd1,  1'b0, '0},
        '{CMD_FRAME,    1'b1, 8'h00, 8'd1,  1'b0, '0},
        '{CMD_POLL,     1'b0, 8'h00, 8'd1,  1'b0, '0},
        // access demand set: class 1 polling
        '{CMD_FRAME,    1'b0, 8'hFF, 8'd1,  1'b0, '0},
        '{CMD_POLL,     1'b0, 8'h00, 8'd1,  1'b0, '0},
        '{CMD_FRAME,    1'b1, 8'h20, 8'd1,  1'b0, '0},
        '{CMD_POLL,     1'b0, 8'h00, 8'd1,  1'b0, '0},
        '{CMD_FRAME,    1'b1, 8'hDF, 8'd1,  1'b0, '0},
        // run past the link timeout so the next poll restarts the link
        '{CMD_TICK,     1'b0, 8'h00, 8'd11, 1'b0, '0},
        '{CMD_POLL,     1'b0, 8'h00, 8'd1,  1'b0, '0},
        '{CMD_POLL,     1'b0, 8'h00, 8'd1,  1'b0, '0},
        '{CMD_FRAME,    1'b0, 8'h00, 8'd1,  1'b0, '0},
        '{CMD_FRAME,    1'b0, 8'h00, 8'd1,  1'b0, '0},
        '{CMD_POLL,     1'b0, 8'h00, 8'd1,  1'b0, '0},
        '{CMD_RESERVED, 1'b0, 8'h00, 8'd1,  1'b0, '0},
        '{CMD_TICK,     1'b1, 8'hFF, 8'd1,  1'b0, '0},
        '{CMD_POLL,     1'b1, 8'hFF, 8'd1,  1'b0, '0}
    };

    function automatic link_frame_t fixed_frame(logic fcv, logic [3:0] code);
        link_frame_t f;
        f.kind = FRAME_FIXED;
        f.ctrl = CTRL_PRM | {2'b00, fcb, fcv, code};
        f.sum  = f.ctrl + cfg_station;
        return f;
    endfunction

    function automatic link_frame_t gi_frame();
        link_frame_t f;
        f.kind = FRAME_GI;
        f.ctrl = CTRL_PRM | {2'b00, fcb, 1'b1, FC_GI};
        // control, address, then the data unit: type, qualifier, cause,
        // address again, function type, two zero bytes
        f.sum  = f.ctrl + cfg_station + ASDU_TYPE_GI + ASDU_VSQ + ASDU_COT_GI
               + cfg_station + ASDU_FUN;
        return f;
    endfunction

    function automatic logic [COUNTER_WIDTH-1:0] sat_inc(logic [COUNTER_WIDTH-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    function automatic rx_mode_t rx_rand_mode();
        case ($urandom_range(0, 3))
            0:       return RX_OPEN;
            1:       return RX_COIN;
            2:       return RX_SPARSE;
            default: return RX_COMB;
        endcase
    endfunction

    // Advance the link sequencer by one event; emits is set when a frame goes out
    task automatic step_link_master(input logic [1:0] cmd, input logic is_variable,
                                    input logic [7:0] ctrl, output logic emits,
                                    output link_frame_t f);
        emits = 1'b0;
        f = '0;
        case (cmd)
            CMD_TICK: begin
                reply_secs = sat_inc(reply_secs);
                gi_secs    = sat_inc(gi_secs);
            end
            CMD_FRAME: begin
                reply_secs = '0;
                fcb = ~fcb;
                if ((ctrl & CTRL_ACD) != 0) begin
                    link_st = LS_CLASS1;
                end else if (!is_variable && gi_pending) begin
                    gi_pending = 1'b0;
                    link_st = LS_GI;
                end else begin
                    link_st = LS_CLASS2;
                end
            end
            CMD_POLL: begin
                emits = 1'b1;
                if (reply_secs > cfg_link_to) link_st = LS_REQ_STS;
                case (link_st)
                    LS_RESET: f = fixed_frame(1'b0, FC_RESET_LINK);
                    LS_REQ_STS: begin
                        link_st = LS_GI;
                        gi_pending = 1'b1;
                        f = fixed_frame(1'b0, FC_RESET_LINK);
                    end
                    LS_CLASS1: f = fixed_frame(1'b1, FC_CLASS1);
                    LS_CLASS2: begin
                        if (gi_secs > cfg_gi_period) begin
                            gi_secs = '0;
                            f = gi_frame();
                        end else if (gi_pending) begin
                            gi_pending = 1'b0;
                            f = gi_frame();
                        end else if (reply_secs > cfg_idle_to) begin
                            link_st = LS_GI;
                            gi_pending = 1'b1;
                            f = fixed_frame(1'b0, FC_RESET_LINK);
                        end else begin
                            f = fixed_frame(1'b1, FC_CLASS2);
                        end
                    end
                    LS_GI: f = gi_frame();
                    default: emits = 1'b0;
                endcase
            end
            default: ;
        endcase
    endtask

    // Offer one beat on the input channel, pacing the sender in bursts with gaps.
    // Called at a rising edge; returns at the edge where the beat is taken.
    task automatic offer_event(input logic [1:0] cmd, input logic is_variable,
                               input logic [7:0] ctrl, input logic typed,
                               input link_frame_t want);
        int          gap;
        int          pick;
        logic        emits;
        link_frame_t f;
        if (burst_left == 0) begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
                gap = 0;
            else if (pick < 8)
                gap = $urandom_range(1, 4);
            else if (pick == 8)
                gap = $urandom_range(5, 12);
            else
                gap = $urandom_range(13, 30);
            burst_left = $urandom_range(1, 40);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid          <= 1'b1;
        s_command        <= cmd;
        s_frame_variable <= is_variable;
        s_control_field  <= ctrl;
        do @(posedge aclk); while (!s_ready);
        step_link_master(cmd, is_variable, ctrl, emits, f);
        if (typed)
            frames_due.push_back(want);
        else if (emits)
            frames_due.push_back(f);
    endtask

    task automatic offer_plain(input logic [1:0] cmd, input logic is_variable,
                               input logic [7:0] ctrl);
        offer_event(cmd, is_variable, ctrl, 1'b0, '0);
    endtask

    // A setup phase then an access phase; the caller drops psel after the last write
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_STATION_ADDR: cfg_station   = value[7:0];
            REG_LINK_TIMEOUT: cfg_link_to   = value[15:0];
            REG_GI_PERIOD:    cfg_gi_period = value[15:0];
            REG_IDLE_TIMEOUT: cfg_idle_to   = value[15:0];
            default: ;
        endcase
    endtask

    // Drain the block, then load all four registers
    task automatic configure(input logic [7:0] station, input logic [15:0] link_to,
                             input logic [15:0] gi_period, input logic [15:0] idle_to);
        s_valid <= 1'b0;
        while (frames_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        write_reg(REG_STATION_ADDR, {24'h0, station});
        write_reg(REG_LINK_TIMEOUT, {16'h0, link_to});
        write_reg(REG_GI_PERIOD, {16'h0, gi_period});
        write_reg(REG_IDLE_TIMEOUT, {16'h0, idle_to});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %02h, actual %02h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Receiver: hold a stall mode for a random stretch, then switch
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_rand_mode();
            rx_left = $urandom_range(16, 160);
        end else begin
            rx_left--;
        end
        rx_count++;
        case (rx_mode)
            RX_OPEN:   m_ready <= 1'b1;
            RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_ready <= ($urandom_range(0, 7) == 0);
            default:   m_ready <= (rx_count % 4 == 3);
        endcase
    end

    // Compare each result beat against the oldest outstanding frame
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (frames_due.size() == 0) begin
                $display("%0t: unexpected frame: expected none, actual kind %0d ctrl %02h sum %02h",
                         $time, m_frame_kind, m_control_byte, m_checksum);
                mismatches++;
            end else begin
                head = frames_due.pop_front();
                check_field("frame_kind", {7'h0, head.kind}, {7'h0, m_frame_kind});
                check_field("control_byte", head.ctrl, m_control_byte);
                check_field("checksum", head.sum, m_checksum);
            end
        end
    end

    // Watchdog: any beat or register access counts as progress
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= HANG_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        int          sent;
        int          run;
        int          pick;
        logic [7:0]  station;
        logic [15:0] link_to;
        logic [15:0] gi_period;
        logic [15:0] idle_to;

        cfg_station   = RST_STATION_ADDR;
        cfg_link_to   = RST_LINK_TIMEOUT;
        cfg_gi_period = RST_GI_PERIOD;
        cfg_idle_to   = RST_IDLE_TIMEOUT;
        link_st       = LS_REQ_STS;
        fcb           = 1'b0;
        gi_pending    = 1'b0;
        reply_secs    = '0;
        gi_secs       = '0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed script on the reset defaults
        foreach (script[i]) begin
            repeat (script[i].repeats)
                offer_event(script[i].cmd, script[i].is_variable, script[i].ctrl,
                            script[i].typed, script[i].want);
        end

        // Timeout boundaries in class 2 polling: the reply counter sits exactly
        // at the link timeout, the interrogation counter above its period.
        configure(8'hFF, EDGE_SECS, EDGE_SECS - 16'd1, 16'hFFFF);
        offer_plain(CMD_FRAME, 1'b1, 8'h00);
        repeat (EDGE_SECS) offer_plain(CMD_TICK, 1'b0, 8'h00);
        offer_plain(CMD_POLL, 1'b0, 8'h00);
        offer_plain(CMD_POLL, 1'b0, 8'h00);
        // drop the link timeout by one: the reply counter now trips it
        configure(8'hFF, EDGE_SECS - 16'd1, EDGE_SECS - 16'd1, 16'hFFFF);
        offer_plain(CMD_POLL, 1'b0, 8'h00);
        offer_plain(CMD_POLL, 1'b0, 8'h00);

        // Random phases, each under its own register setting
        for (int phase = 0; phase < PHASES; phase++) begin
            station = 8'($urandom);
            case (phase)
                0: begin
                    station = 8'h00; link_to = '0; gi_period = '0; idle_to = '0;
                end
                1: begin
                    station = 8'hFF; link_to = 16'hFFFF; gi_period = 16'hFFFF;
                    idle_to = 16'hFFFF;
                end
                2: begin
                    // long link timeout so the class 2 idle restart gets its turn
                    link_to = 16'hFFFF;
                    gi_period = 16'($urandom_range(5, 40));
                    idle_to = 16'($urandom_range(0, 15));
                end
                3: begin
                    link_to = 16'($urandom_range(0, 20));
                    gi_period = 16'($urandom_range(0, 60));
                    idle_to = 16'($urandom_range(0, 20));
                end
                4: begin
                    link_to = 16'($urandom_range(0, 30));
                    gi_period = '0;
                    idle_to = 16'hFFFF;
                end
                default: begin
                    link_to = 16'($urandom_range(0, 25));
                    gi_period = 16'($urandom_range(0, 25));
                    idle_to = 16'($urandom_range(0, 25));
                end
            endcase
            configure(station, link_to, gi_period, idle_to);

            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                pick = $urandom_range(0, 99);
                if (pick < 35) begin
                    // a run of ticks, now and then long enough to cross a timeout
                    run = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(1, 4);
                    repeat (run) offer_plain(CMD_TICK, 1'($urandom_range(0, 1)),
                                             8'($urandom));
                    sent += run;
                end else if (pick < 70) begin
                    offer_plain(CMD_POLL, 1'($urandom_range(0, 1)), 8'($urandom));
                    sent++;
                end else if (pick < 95) begin
                    offer_plain(CMD_FRAME, 1'($urandom_range(0, 1)), 8'($urandom));
                    sent++;
                end else begin
                    offer_plain(CMD_RESERVED, 1'($urandom_range(0, 1)), 8'($urandom));
                end
            end
        end

        // Let the last frames out, then allow for the pipeline to settle
        s_valid <= 1'b0;
        while (frames_due.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && frames_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
